// ===== rtl/crrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Content-Range resume check.
// Depends on nothing; every other file of the block uses it.
package crrc_pkg;

  // Widths of the channel fields.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned STATUS_W   = 10;
  localparam int unsigned OFFSET_W   = 63;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PIECES     = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           verdict_t;
  typedef logic [VAL_W-1:0]     acc_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_STATUS = 1'd0;
  localparam cfg_idx_t CFG_OFFSET = 1'd1;

  localparam logic [STATUS_W-1:0] STATUS_RESET   = 10'd200;
  localparam logic [STATUS_W-1:0] STATUS_PARTIAL = 10'd206;

  // Resume verdict codes.
  localparam verdict_t VERDICT_HONOURED = 2'd0;
  localparam verdict_t VERDICT_FULL     = 2'd1;
  localparam verdict_t VERDICT_UNUSABLE = 2'd2;

  // Largest accumulator that may still take one more digit (limit / 10).
  localparam acc_t ACC_LIMIT_DIV10 = 64'd922337203685477580;

  // Value that stands for an unknown or unparsable number, and that minus one.
  localparam acc_t VAL_NONE       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam acc_t VAL_NONE_MINUS = 64'hFFFF_FFFF_FFFF_FFFE;

  // Status of one number while it is collected.
  typedef struct packed {
    logic sign;
    logic neg;
    logic digit;
    logic closed;
    logic bad;
  } piece_flags_t;

  // Parser state taken at the last byte of a header.
  typedef struct packed {
    logic                          at_total;
    piece_flags_t [PIECES-1:0]     flags;
    logic [PIECES-1:0][VAL_W-1:0]  acc;
  } snap_t;

  // Configuration as seen by the result logic.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
  } cfg_t;

endpackage

// ===== rtl/crrc_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for the header byte, result and configuration channels.
// Depends on crrc_pkg for field widths.

interface crrc_in_if;
  logic                         valid;
  logic                         ready;
  logic [crrc_pkg::BYTE_W-1:0]  header_byte;
  logic                         byte_valid;
  logic                         is_last;
  modport source (output valid, header_byte, byte_valid, is_last, input ready);
  modport sink (input valid, header_byte, byte_valid, is_last, output ready);
endinterface

interface crrc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             parsed_ok;
  logic signed [crrc_pkg::VAL_W-1:0] first_value;
  logic signed [crrc_pkg::VAL_W-1:0] last_value;
  logic signed [crrc_pkg::VAL_W-1:0] total_value;
  crrc_pkg::verdict_t               verdict;
  modport source (output valid, parsed_ok, first_value, last_value, total_value, verdict,
                  input ready);
  modport sink (input valid, parsed_ok, first_value, last_value, total_value, verdict,
                output ready);
endinterface

interface crrc_cfg_if;
  logic                            valid;
  logic                            ready;
  crrc_pkg::cfg_idx_t              index;
  logic [crrc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/crrc_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers: response status code and requested resume offset.
// Depends on crrc_pkg and crrc_cfg_if.
module crrc_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  crrc_cfg_if.sink        cfg_chan,
  output crrc_pkg::cfg_t  cfg
);

  logic [crrc_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [crrc_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic                          wr_en;

  // Writes are always taken.
  assign cfg_chan.ready = 1'b1;
  assign wr_en          = cfg_chan.valid;

  // Decode the register index.
  always_comb begin
    status_nxt = status_r;
    offset_nxt = offset_r;
    if (wr_en) begin
      case (cfg_chan.index)
        crrc_pkg::CFG_STATUS: status_nxt = cfg_chan.data[crrc_pkg::STATUS_W-1:0];
        crrc_pkg::CFG_OFFSET: offset_nxt = cfg_chan.data[crrc_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= crrc_pkg::STATUS_RESET;
      offset_r <= '0;
    end else begin
      status_r <= status_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign cfg.status = status_r;
  assign cfg.offset = offset_r;

endmodule

// ===== rtl/crrc_parser.sv =====
`timescale 1ns / 1ps
// Byte parser: tracks the header phase, matches the unit and accumulates the numbers.
// Depends on crrc_pkg and crrc_in_if; hands a state snapshot to crrc_finish.
module crrc_parser (
  input  logic             clk,
  input  logic             rst_n,
  crrc_in_if.sink          in_chan,
  output crrc_pkg::snap_t  snap,
  output logic             snap_valid,
  input  logic             snap_ready
);

  // Parse phases.
  localparam logic [2:0] PH_LEAD       = 3'd0;
  localparam logic [2:0] PH_UNIT       = 3'd1;
  localparam logic [2:0] PH_RANGE_LEAD = 3'd2;
  localparam logic [2:0] PH_FIRST      = 3'd3;
  localparam logic [2:0] PH_LAST       = 3'd4;
  localparam logic [2:0] PH_TOTAL      = 3'd5;
  localparam logic [2:0] PH_FAIL       = 3'd6;

  localparam logic [2:0] UNIT_LEN = 3'd5;
  localparam logic [2:0] UNIT_BAD = 3'd7;

  localparam logic [1:0] PIECE_FIRST = 2'd0;
  localparam logic [1:0] PIECE_LAST  = 2'd1;
  localparam logic [1:0] PIECE_TOTAL = 2'd2;

  typedef struct packed {
    crrc_pkg::piece_flags_t flags;
    crrc_pkg::acc_t         acc;
  } piece_t;

  logic [2:0]                                   phase_r, phase_nxt;
  logic [2:0]                                   cnt_r, cnt_nxt;
  crrc_pkg::piece_flags_t [crrc_pkg::PIECES-1:0] flags_r, flags_nxt;
  logic [crrc_pkg::PIECES-1:0][crrc_pkg::VAL_W-1:0] acc_r, acc_nxt;
  logic                                         snap_valid_r, snap_valid_nxt;
  crrc_pkg::snap_t                              snap_r, snap_nxt;

  logic       accept;
  logic       feed;
  logic [7:0] c;
  logic       ws;
  logic [7:0] lc;
  logic [1:0] piece_sel;
  logic       piece_wr;
  piece_t     piece_in;
  piece_t     piece_out;

  // Expected letters of the unit, in lower case.
  function automatic logic [7:0] unit_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // One byte into one number: sign, digits with overflow check, closing whitespace.
  function automatic piece_t feed_piece(input piece_t p, input logic [7:0] ch,
                                        input logic is_ws);
    piece_t         r;
    logic           started;
    logic [3:0]     d;
    crrc_pkg::acc_t thr;
    r       = p;
    started = p.flags.sign | p.flags.digit;
    d       = ch[3:0];
    if (p.flags.neg) begin
      thr = (d <= 4'd8) ? crrc_pkg::ACC_LIMIT_DIV10 : crrc_pkg::ACC_LIMIT_DIV10 - 64'd1;
    end else begin
      thr = (d <= 4'd7) ? crrc_pkg::ACC_LIMIT_DIV10 : crrc_pkg::ACC_LIMIT_DIV10 - 64'd1;
    end
    if (!p.flags.bad) begin
      if (is_ws) begin
        if (started) r.flags.closed = 1'b1;
      end else if (p.flags.closed) begin
        r.flags.bad = 1'b1;
      end else if (!started && (ch == 8'h2B || ch == 8'h2D)) begin
        r.flags.sign = 1'b1;
        r.flags.neg  = (ch == 8'h2D);
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
        if (p.acc > thr) begin
          r.flags.bad = 1'b1;
        end else begin
          r.acc = (p.acc << 3) + (p.acc << 1) + {60'd0, d};
        end
        r.flags.digit = 1'b1;
      end else begin
        r.flags.bad = 1'b1;
      end
    end
    return r;
  endfunction

  assign in_chan.ready = !snap_valid_r || snap_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign feed          = accept && in_chan.byte_valid;
  assign c             = in_chan.header_byte;
  assign ws            = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign lc            = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;

  // The number that the current phase feeds.
  always_comb begin
    case (phase_r)
      PH_LAST:  piece_sel = PIECE_LAST;
      PH_TOTAL: piece_sel = PIECE_TOTAL;
      default:  piece_sel = PIECE_FIRST;
    endcase
  end

  assign piece_in.flags = flags_r[piece_sel];
  assign piece_in.acc   = acc_r[piece_sel];
  assign piece_out      = feed_piece(piece_in, c, ws);

  // Phase and unit tracking.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    piece_wr  = 1'b0;
    if (feed) begin
      case (phase_r)
        PH_LEAD, PH_UNIT: begin
          if (!(phase_r == PH_LEAD && ws)) begin
            phase_nxt = PH_UNIT;
            if (c == 8'h20) begin
              phase_nxt = (cnt_r == UNIT_LEN) ? PH_RANGE_LEAD : PH_FAIL;
            end else if (cnt_r < UNIT_LEN) begin
              cnt_nxt = (lc == unit_char(cnt_r)) ? cnt_r + 3'd1 : UNIT_BAD;
            end else begin
              cnt_nxt = UNIT_BAD;
            end
          end
        end
        PH_RANGE_LEAD: begin
          if (!ws) begin
            if (c == 8'h2D || c == 8'h2F) begin
              phase_nxt = PH_FAIL;
            end else begin
              phase_nxt = PH_FIRST;
              piece_wr  = 1'b1;
            end
          end
        end
        PH_FIRST: begin
          if (c == 8'h2D)      phase_nxt = PH_LAST;
          else if (c == 8'h2F) phase_nxt = PH_FAIL;
          else                 piece_wr  = 1'b1;
        end
        PH_LAST: begin
          if (c == 8'h2F) phase_nxt = PH_TOTAL;
          else            piece_wr  = 1'b1;
        end
        PH_TOTAL: piece_wr = 1'b1;
        default: ;
      endcase
    end
  end

  // Write back the number that took the byte.
  always_comb begin
    flags_nxt = flags_r;
    acc_nxt   = acc_r;
    if (piece_wr) begin
      flags_nxt[piece_sel] = piece_out.flags;
      acc_nxt[piece_sel]   = piece_out.acc;
    end
  end

  // Snapshot on the last byte; it waits until the result stage takes it.
  always_comb begin
    snap_valid_nxt = snap_valid_r && !snap_ready;
    snap_nxt       = snap_r;
    if (accept && in_chan.is_last) begin
      snap_valid_nxt    = 1'b1;
      snap_nxt.at_total = (phase_nxt == PH_TOTAL);
      snap_nxt.flags    = flags_nxt;
      snap_nxt.acc      = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      cnt_r        <= '0;
      flags_r      <= '0;
      acc_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      if (accept && in_chan.is_last) begin
        phase_r <= PH_LEAD;
        cnt_r   <= '0;
        flags_r <= '0;
        acc_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        flags_r <= flags_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap       = snap_r;
  assign snap_valid = snap_valid_r;

  // A header end always leaves a snapshot and a cleared parser behind.
  a_last_snap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.is_last |=> snap_valid_r)
    else $error("last byte left no snapshot");

  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.is_last |=> phase_r == PH_LEAD && cnt_r == 3'd0)
    else $error("parser not cleared after last byte");

  // The unit counter only runs past the unit length when it marks a mismatch.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= UNIT_LEN || cnt_r == UNIT_BAD)
    else $error("unit counter out of range");

endmodule

// ===== rtl/crrc_finish.sv =====
`timescale 1ns / 1ps
// Result path: turns a parser snapshot into signed values, then into the verdict.
// Depends on crrc_pkg and crrc_out_if; fed by crrc_parser and crrc_cfg_regs.
module crrc_finish (
  input  logic             clk,
  input  logic             rst_n,
  input  crrc_pkg::snap_t  snap,
  input  logic             snap_valid,
  output logic             snap_ready,
  input  crrc_pkg::cfg_t   cfg,
  crrc_out_if.source       out_chan
);

  // Value stage.
  logic            s2_valid_r, s2_valid_nxt;
  logic            s2_parsed_r, s2_is206_r;
  crrc_pkg::acc_t  s2_first_r, s2_last_r, s2_total_r, s2_total_m1_r;
  logic            parsed_nxt, is206_nxt, use_parse;
  crrc_pkg::acc_t  first_nxt, last_nxt, total_nxt, total_m1_nxt;
  logic [crrc_pkg::PIECES-1:0]      ok;
  logic [crrc_pkg::PIECES-1:0][crrc_pkg::VAL_W-1:0] val;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_parsed_r;
  crrc_pkg::acc_t     out_first_r, out_last_r, out_total_r;
  crrc_pkg::verdict_t out_verdict_r, verdict_nxt;

  logic out_free, s2_free, s2_adv, snap_take;
  logic first_is_off, last_is_end, total_pos, first_zero;

  // Stall chain: each stage moves when the one after it has room.
  assign out_free   = !out_valid_r || out_chan.ready;
  assign s2_adv     = s2_valid_r && out_free;
  assign s2_free    = !s2_valid_r || out_free;
  assign snap_ready = s2_free;
  assign snap_take  = snap_valid && s2_free;

  // Signed values of the three numbers.
  always_comb begin
    for (int p = 0; p < crrc_pkg::PIECES; p++) begin
      ok[p]  = snap.flags[p].digit && !snap.flags[p].bad;
      val[p] = !ok[p] ? crrc_pkg::VAL_NONE
             : (snap.flags[p].neg ? (~snap.acc[p] + 64'd1) : snap.acc[p]);
    end
  end

  assign is206_nxt  = (cfg.status == crrc_pkg::STATUS_PARTIAL);
  assign use_parse  = is206_nxt && snap.at_total;
  assign parsed_nxt = use_parse && ok[0] && ok[1];
  assign first_nxt  = use_parse ? val[0] : crrc_pkg::VAL_NONE;
  assign last_nxt   = use_parse ? val[1] : crrc_pkg::VAL_NONE;
  assign total_nxt  = use_parse ? val[2] : crrc_pkg::VAL_NONE;

  // Total minus one straight from the accumulator: for a negative total it is ~acc.
  always_comb begin
    if (use_parse && ok[2]) begin
      total_m1_nxt = snap.flags[2].neg ? ~snap.acc[2] : snap.acc[2] - 64'd1;
    end else begin
      total_m1_nxt = crrc_pkg::VAL_NONE_MINUS;
    end
  end

  assign s2_valid_nxt = snap_take || (s2_valid_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      s2_parsed_r   <= parsed_nxt;
      s2_is206_r    <= is206_nxt;
      s2_first_r    <= first_nxt;
      s2_last_r     <= last_nxt;
      s2_total_r    <= total_nxt;
      s2_total_m1_r <= total_m1_nxt;
    end
  end

  // Resume verdict.
  assign first_is_off = (s2_first_r == {1'b0, cfg.offset});
  assign last_is_end  = (s2_last_r == s2_total_m1_r);
  assign total_pos    = !s2_total_r[crrc_pkg::VAL_W-1] && (s2_total_r != '0);
  assign first_zero   = (s2_first_r == '0);

  always_comb begin
    if (s2_parsed_r && first_is_off && (s2_total_r[crrc_pkg::VAL_W-1] || last_is_end)) begin
      verdict_nxt = crrc_pkg::VERDICT_HONOURED;
    end else if (s2_is206_r &&
                 !(s2_parsed_r && first_zero && total_pos && last_is_end)) begin
      verdict_nxt = crrc_pkg::VERDICT_UNUSABLE;
    end else begin
      verdict_nxt = crrc_pkg::VERDICT_FULL;
    end
  end

  assign out_valid_nxt = s2_adv || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_parsed_r  <= s2_parsed_r;
      out_first_r   <= s2_first_r;
      out_last_r    <= s2_last_r;
      out_total_r   <= s2_total_r;
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.parsed_ok   = out_parsed_r;
  assign out_chan.first_value = out_first_r;
  assign out_chan.last_value  = out_last_r;
  assign out_chan.total_value = out_total_r;
  assign out_chan.verdict     = out_verdict_r;

  // An item that did not parse is never honoured.
  a_unparsed_not_honoured: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_parsed_r |-> out_verdict_r != crrc_pkg::VERDICT_HONOURED)
    else $error("unparsed header honoured");

  // A value stage blocked by a full output keeps its item.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_free |=> s2_valid_r && $stable(s2_first_r) && $stable(s2_total_r))
    else $error("value stage lost an item under stall");

  // Only a status of 206 can yield a parsed result.
  a_parsed_206: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_parsed_r |-> s2_is206_r)
    else $error("parsed without partial status");

endmodule

// ===== rtl/content_range_resume_check.sv =====
`timescale 1ns / 1ps
// Top level of the Content-Range resume check.
// Depends on crrc_pkg, crrc_if, crrc_cfg_regs, crrc_parser and crrc_finish.
//
//  Channel    Dir  Handshake          Item
//  in_chan    in   valid/ready        header_byte, byte_valid, is_last
//  out_chan   out  valid/ready        parsed_ok, first/last/total_value, verdict
//  cfg_chan   in   valid/ready        index (0 status_code, 1 resume_offset), data
//
// One header byte is taken every cycle while in_chan.ready is high; the byte updates the
// parser state directly. After the last byte is taken, the result passes the snapshot
// register, the value register and the verdict/output register, in that order.
// Reset (rst_n low, synchronous) sets status_code to 200, resume_offset to 0 and
// empties the parser and all stages. A stalled output holds its result; the stages
// behind it fill up and in_chan.ready drops once the snapshot register is occupied.
module content_range_resume_check (
  input  logic        clk,
  input  logic        rst_n,
  crrc_in_if.sink     in_chan,
  crrc_out_if.source  out_chan,
  crrc_cfg_if.sink    cfg_chan
);

  crrc_pkg::cfg_t  cfg;
  crrc_pkg::snap_t snap;
  logic            snap_valid;
  logic            snap_ready;

  crrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  crrc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  crrc_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .cfg        (cfg),
    .out_chan   (out_chan)
  );

endmodule
